[rtl/core/scag_pkg.sv]
// shared types, constants and helpers of the strided copy address generator
// no dependencies; every other file of the block refers to this package by scoped names
package scag_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int DIM_W       = 16;
    localparam int DIM_SEL_W   = 2;
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 3;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_MAX     = 16;

    typedef enum logic [2:0] {
        REG_DIM_COUNT     = 3'd0,
        REG_DIM_SIZES     = 3'd1,
        REG_SRC_STRIDES   = 3'd2,
        REG_DST_STRIDES   = 3'd3,
        REG_SRC_BASE      = 3'd4,
        REG_DST_BASE      = 3'd5,
        REG_ELEMENT_BYTES = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]      dim_count;
        logic [63:0]           dim_sizes;
        logic [63:0]           src_strides;
        logic [63:0]           dst_strides;
        logic [ADDR_W-1:0]     src_base;
        logic [ADDR_W-1:0]     dst_base;
        logic [LEN_W-1:0]      element_bytes;
    } t_cfg;

    // one element as classified by the front part
    typedef struct packed {
        logic [MAX_DIMS-1:0][DIM_W-1:0] idx;
        logic                           last;
    } t_cmd;

    function automatic logic [DIM_W-1:0] lane16(input logic [63:0] word_v,
                                                input logic [DIM_SEL_W-1:0] d);
        return word_v[d*DIM_W +: DIM_W];
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] eb);
        logic [LEN_W-1:0] v;
        if (eb == '0) begin
            v = LEN_W'(1);
        end else if (eb > LEN_W'(LEN_MAX)) begin
            v = LEN_W'(LEN_MAX);
        end else begin
            v = eb;
        end
        return v;
    endfunction

endpackage

[rtl/core/scag_regs.sv]
// configuration register file with an apb-style write/read port
// depends on scag_pkg for the register indexes and the t_cfg struct
module scag_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scag_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [scag_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [scag_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output scag_pkg::t_cfg                   o_cfg
);

    scag_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [2:0]     w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[5:3];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_count     <= scag_pkg::CNT_W'(1);
            r_cfg.dim_sizes     <= 64'd1;
            r_cfg.src_strides   <= '0;
            r_cfg.dst_strides   <= '0;
            r_cfg.src_base      <= '0;
            r_cfg.dst_base      <= '0;
            r_cfg.element_bytes <= scag_pkg::LEN_W'(4);
        end else if (w_wr) begin
            case (w_idx)
                scag_pkg::REG_DIM_COUNT:     r_cfg.dim_count     <= pwdata[scag_pkg::CNT_W-1:0];
                scag_pkg::REG_DIM_SIZES:     r_cfg.dim_sizes     <= pwdata;
                scag_pkg::REG_SRC_STRIDES:   r_cfg.src_strides   <= pwdata;
                scag_pkg::REG_DST_STRIDES:   r_cfg.dst_strides   <= pwdata;
                scag_pkg::REG_SRC_BASE:      r_cfg.src_base      <= pwdata[scag_pkg::ADDR_W-1:0];
                scag_pkg::REG_DST_BASE:      r_cfg.dst_base      <= pwdata[scag_pkg::ADDR_W-1:0];
                scag_pkg::REG_ELEMENT_BYTES: r_cfg.element_bytes <= pwdata[scag_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            scag_pkg::REG_DIM_COUNT:     prdata = 64'(r_cfg.dim_count);
            scag_pkg::REG_DIM_SIZES:     prdata = r_cfg.dim_sizes;
            scag_pkg::REG_SRC_STRIDES:   prdata = r_cfg.src_strides;
            scag_pkg::REG_DST_STRIDES:   prdata = r_cfg.dst_strides;
            scag_pkg::REG_SRC_BASE:      prdata = 64'(r_cfg.src_base);
            scag_pkg::REG_DST_BASE:      prdata = 64'(r_cfg.dst_base);
            scag_pkg::REG_ELEMENT_BYTES: prdata = 64'(r_cfg.element_bytes);
            default:                     prdata = '0;
        endcase
    end

endmodule

[rtl/core/scag_front.sv]
// front part: accepts transactions, keeps the per-dimension index counters
// and emits one classified element (masked indices plus last flag); uses scag_pkg
module scag_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scag_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  logic           i_restart,
    output logic           o_stall,
    input  logic           i_full,
    output logic           o_push,
    output scag_pkg::t_cmd o_cmd
);

    logic [scag_pkg::DIM_W-1:0] r_idx [scag_pkg::MAX_DIMS];
    logic [scag_pkg::DIM_W-1:0] n_idx [scag_pkg::MAX_DIMS];
    logic [scag_pkg::DIM_W-1:0] w_cur [scag_pkg::MAX_DIMS];
    logic [scag_pkg::CNT_W-1:0] w_n;
    logic                       w_carry;
    logic                       w_accept;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    // counts above the supported number of dimensions saturate
    assign w_n = (i_cfg.dim_count > scag_pkg::CNT_W'(scag_pkg::MAX_DIMS)) ?
                 scag_pkg::CNT_W'(scag_pkg::MAX_DIMS) : i_cfg.dim_count;

    // last active dimension counts first, carry ripples toward dimension 0
    always_comb begin
        logic [scag_pkg::DIM_W:0]   v_inc;
        logic [scag_pkg::DIM_W-1:0] v_ext;
        w_carry = 1'b1;
        v_inc   = '0;
        v_ext   = '0;
        for (int d = scag_pkg::MAX_DIMS - 1; d >= 0; d--) begin
            w_cur[d]     = i_restart ? '0 : r_idx[d];
            o_cmd.idx[d] = (scag_pkg::CNT_W'(d) < w_n) ? w_cur[d] : '0;
            n_idx[d]     = w_cur[d];
            if ((scag_pkg::CNT_W'(d) < w_n) && w_carry) begin
                v_ext = scag_pkg::lane16(i_cfg.dim_sizes, scag_pkg::DIM_SEL_W'(d));
                if (v_ext == '0) begin
                    v_ext = scag_pkg::DIM_W'(1);
                end
                v_inc = {1'b0, w_cur[d]} + (scag_pkg::DIM_W+1)'(1);
                if (v_inc < {1'b0, v_ext}) begin
                    n_idx[d] = v_inc[scag_pkg::DIM_W-1:0];
                    w_carry  = 1'b0;
                end else begin
                    n_idx[d] = '0;
                end
            end
        end
        // carry out of dimension 0 ends the copy, every index restarts
        if (w_carry) begin
            for (int d = 0; d < scag_pkg::MAX_DIMS; d++) begin
                n_idx[d] = '0;
            end
        end
        o_cmd.last = w_carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < scag_pkg::MAX_DIMS; d++) begin
                r_idx[d] <= '0;
            end
        end else if (w_accept) begin
            for (int d = 0; d < scag_pkg::MAX_DIMS; d++) begin
                r_idx[d] <= n_idx[d];
            end
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && o_cmd.last) |=> (r_idx[0] == '0) && (r_idx[1] == '0) &&
                                     (r_idx[2] == '0) && (r_idx[3] == '0))
        else $error("indices not cleared after last element");
`endif

endmodule

[rtl/core/scag_queue.sv]
// short queue of classified elements between the front and back parts
// depends on scag_pkg for t_cmd and the queue depth
module scag_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scag_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output scag_pkg::t_cmd o_cmd
);

    scag_pkg::t_cmd                r_mem [scag_pkg::QUEUE_DEPTH];
    logic [scag_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [scag_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [scag_pkg::Q_CNT_W-1:0]  r_count;
    logic                          w_push;
    logic                          w_pop;

    assign o_full  = (r_count == scag_pkg::Q_CNT_W'(scag_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == scag_pkg::Q_PTR_W'(scag_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + scag_pkg::Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == scag_pkg::Q_PTR_W'(scag_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + scag_pkg::Q_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + scag_pkg::Q_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - scag_pkg::Q_CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= scag_pkg::Q_CNT_W'(scag_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + scag_pkg::Q_CNT_W'(1)))
        else $error("queue count did not follow a push");
`endif

endmodule

[rtl/core/scag_back.sv]
// back part: index-times-stride products, then base plus sum into the output register
// depends on scag_pkg for t_cfg, t_cmd and lane helpers
module scag_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scag_pkg::t_cfg              i_cfg,
    input  logic                        i_q_valid,
    input  scag_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [scag_pkg::ADDR_W-1:0] o_src_address,
    output logic [scag_pkg::ADDR_W-1:0] o_dst_address,
    output logic [scag_pkg::LEN_W-1:0]  o_length_bytes,
    output logic                        o_last
);

    logic [scag_pkg::ADDR_W-1:0] r_sprod [scag_pkg::MAX_DIMS];
    logic [scag_pkg::ADDR_W-1:0] r_dprod [scag_pkg::MAX_DIMS];
    logic                        r_s1_v;
    logic                        r_s1_last;
    logic                        r_out_v;
    logic [scag_pkg::ADDR_W-1:0] r_src;
    logic [scag_pkg::ADDR_W-1:0] r_dst;
    logic [scag_pkg::LEN_W-1:0]  r_len;
    logic                        r_last;
    logic [scag_pkg::ADDR_W-1:0] w_ssum;
    logic [scag_pkg::ADDR_W-1:0] w_dsum;
    logic                        w_out_free;
    logic                        w_s1_free;
    logic                        w_s1_adv;

    assign w_out_free = !r_out_v || !i_stall;
    assign w_s1_adv   = r_s1_v && w_out_free;
    assign w_s1_free  = !r_s1_v || w_out_free;
    assign o_pop      = i_q_valid && w_s1_free;

    // sums wrap modulo 2^32
    always_comb begin
        w_ssum = i_cfg.src_base;
        w_dsum = i_cfg.dst_base;
        for (int d = 0; d < scag_pkg::MAX_DIMS; d++) begin
            w_ssum = w_ssum + r_sprod[d];
            w_dsum = w_dsum + r_dprod[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int d = 0; d < scag_pkg::MAX_DIMS; d++) begin
                r_sprod[d] <= scag_pkg::ADDR_W'(i_cmd.idx[d]) * scag_pkg::ADDR_W'(
                    scag_pkg::lane16(i_cfg.src_strides, scag_pkg::DIM_SEL_W'(d)));
                r_dprod[d] <= scag_pkg::ADDR_W'(i_cmd.idx[d]) * scag_pkg::ADDR_W'(
                    scag_pkg::lane16(i_cfg.dst_strides, scag_pkg::DIM_SEL_W'(d)));
            end
            r_s1_last <= i_cmd.last;
        end
        if (w_s1_adv) begin
            r_src  <= w_ssum;
            r_dst  <= w_dsum;
            r_len  <= scag_pkg::clamp_len(i_cfg.element_bytes);
            r_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_v <= o_pop;
            end
            if (w_out_free) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    assign o_valid        = r_out_v;
    assign o_src_address  = r_src;
    assign o_dst_address  = r_dst;
    assign o_length_bytes = r_len;
    assign o_last         = r_last;

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_out_v && i_stall) |=> r_s1_v)
        else $error("product stage lost an element under stall");
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_len >= scag_pkg::LEN_W'(1)) &&
                    (r_len <= scag_pkg::LEN_W'(scag_pkg::LEN_MAX)))
        else $error("copy length out of range");
`endif

endmodule

[rtl/core/strided_copy_address_generator.sv]
// Strided copy address generator. One element transaction is accepted per clock and one
// result is delivered per clock when neither side stalls. The front part computes the
// next per-dimension index counters combinationally (a four-step carry chain of 16-bit
// increments), so that counter loop sets the rate of one element per cycle. The back part
// registers the index-times-stride products and then the base-plus-sum into the output
// register. A four-entry queue between the parts absorbs output stalls; input stall
// rises only when it is full. Configuration registers are 64-bit at byte address 8*i;
// the user must keep them written while idle only; the block does not enforce this.
// top level; instantiates scag_regs, scag_front, scag_queue and scag_back, uses scag_pkg
module strided_copy_address_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scag_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [scag_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [scag_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_restart,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [scag_pkg::ADDR_W-1:0]      o_src_address,
    output logic [scag_pkg::ADDR_W-1:0]      o_dst_address,
    output logic [scag_pkg::LEN_W-1:0]       o_length_bytes,
    output logic                             o_last
);

    scag_pkg::t_cfg w_cfg;
    scag_pkg::t_cmd w_front_cmd;
    scag_pkg::t_cmd w_q_cmd;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_q_valid;

    scag_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    scag_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (i_in_valid),
        .i_restart (i_restart),
        .o_stall   (o_in_stall),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_front_cmd)
    );

    scag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    scag_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_valid      (w_q_valid),
        .i_cmd          (w_q_cmd),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_src_address  (o_src_address),
        .o_dst_address  (o_dst_address),
        .o_length_bytes (o_length_bytes),
        .o_last         (o_last)
    );

endmodule
